/* rtl/rsput_pkg.sv */
`timescale 1ns / 1ps
package rsput_pkg;

   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int CSR_W   = 11;

   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;

   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   localparam logic ST_OK  = 1'b0;
   localparam logic ST_BAD = 1'b1;

   typedef struct packed {
      logic                      action;
      logic [INDEX_W-1:0]        index;
      logic [INDEX_W-1:0]        range_end;
      logic signed [VALUE_W-1:0] value;
   } rsput_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sum;
      logic                      status;
   } rsput_result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } rsput_stat_type;

endpackage

/* rtl/rsput_chan_if.sv */
`timescale 1ns / 1ps
interface rsput_req_if;
   import rsput_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [INDEX_W-1:0]        index;
   logic [INDEX_W-1:0]        range_end;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output action, output index, output range_end,
                   output value, input ready);
   modport sink   (input valid, input action, input index, input range_end,
                   input value, output ready);
endinterface

interface rsput_rsp_if;
   import rsput_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] sum;
   logic                      status;

   modport source (output valid, output sum, output status, input ready);
   modport sink   (input valid, input sum, input status, output ready);
endinterface

/* rtl/range_sum_point_update_tree.sv */
`timescale 1ns / 1ps
// channel   dir   transfer when        payload
// req_chan  in    valid && ready       action, index, range_end, value
// rsp_chan  out   valid && ready       sum, status
// csr       in    csr_we high          csr_wdata (elements in use)
//
// an update walks one root-to-leaf path and a query at most two such paths
// over L = ceil(log2 n) + 1 tree levels; the single node memory read port,
// one node per cycle, paces the walk
// after reset a clearing pass over the 4 * MAX_ELEMENTS node words zeroes both
// memories, no request is taken meanwhile; csr writes are taken at any time
// a finished result sits in the output register while the next request walks
module range_sum_point_update_tree #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [rsput_pkg::CSR_W-1:0]   csr_wdata,
   rsput_req_if.sink                     req_chan,
   rsput_rsp_if.source                   rsp_chan
);
   import rsput_pkg::*;

   localparam int NW = $clog2(MAX_ELEMENTS + 1);

   logic [CSR_W-1:0]   csr_ff, csr_in;
   logic [NW-1:0]      n_eff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic               rsp_status_ff, rsp_status_in;

   rsput_item_type     item;
   rsput_stat_type     stat;
   rsput_result_type   result;
   logic               start;
   logic               take;

   always_comb begin
      n_eff = (32'(csr_ff) > 32'(MAX_ELEMENTS)) ? NW'(MAX_ELEMENTS) : NW'(csr_ff);
      csr_in = csr_we ? csr_wdata : csr_ff;

      item.action    = req_chan.action;
      item.index     = req_chan.index;
      item.range_end = req_chan.range_end;
      item.value     = req_chan.value;

      start = req_chan.valid && stat.idle;
      take  = stat.done && (!rsp_valid_ff || rsp_chan.ready);

      rsp_valid_in  = rsp_valid_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      if (take) begin
         rsp_valid_in  = 1'b1;
         rsp_sum_in    = result.sum;
         rsp_status_in = result.status;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   rsput_walker #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_walker (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .item   (item),
      .n_eff  (n_eff),
      .take   (take),
      .stat   (stat),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready  = stat.idle;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.sum    = rsp_sum_ff;
   assign rsp_chan.status = rsp_status_ff;

`ifndef SYNTHESIS
   logic [1:0] inflight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + 2'(req_chan.valid && req_chan.ready)
                        - 2'(rsp_chan.valid && rsp_chan.ready);
      end
   end

   // at most one item walking and one result waiting
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff != 2'd3)
      else $error("more than two items in flight");

   // a shown result always belongs to an accepted item
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> inflight_ff != 2'd0)
      else $error("result without an accepted item");

   // no request while a finished result has not moved to the output register
   a_no_accept_while_done: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> !req_chan.ready)
      else $error("request taken before result handoff");

   // rejected items carry a zero sum
   a_bad_sum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_BAD |-> rsp_sum_ff == '0)
      else $error("rejected item with nonzero sum");
`endif

endmodule

/* rtl/rsput_ram.sv */
`timescale 1ns / 1ps
module rsput_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/rsput_walker.sv */
`timescale 1ns / 1ps
module rsput_walker #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  rsput_pkg::rsput_item_type            item,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0]    n_eff,
   input  logic                                 take,
   output rsput_pkg::rsput_stat_type            stat,
   output rsput_pkg::rsput_result_type          result
);
   import rsput_pkg::*;

   localparam int NW         = $clog2(MAX_ELEMENTS + 1);
   localparam int PW         = $clog2(MAX_ELEMENTS);
   localparam int LEAF_DEPTH = 2 ** PW;
   localparam int NODE_DEPTH = 4 * MAX_ELEMENTS;
   localparam int KW         = $clog2(NODE_DEPTH);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LEAF, S_UWALK, S_QDESC, S_QLEFT, S_QRIGHT, S_QDRAIN, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [PW-1:0]      qa_ff, qa_in, qb_ff, qb_in;
   logic [VALUE_W-1:0] val_ff, val_in, delta_ff, delta_in, acc_ff, acc_in;
   logic [KW-1:0]      k_ff, k_in, sk_ff, sk_in, clr_ff, clr_in;
   logic [PW-1:0]      lo_ff, lo_in, hi_ff, hi_in, slo_ff, slo_in, shi_ff, shi_in;
   logic               pend_ff, pend_in;
   logic [VALUE_W-1:0] res_sum_ff, res_sum_in;
   logic               res_status_ff, res_status_in;

   logic               leaf_we;
   logic [PW-1:0]      leaf_waddr, leaf_raddr;
   logic [VALUE_W-1:0] leaf_wdata, leaf_rdata;
   logic               node_we;
   logic [KW-1:0]      node_waddr, node_raddr;
   logic [VALUE_W-1:0] node_wdata, node_rdata;

   logic [PW-1:0]      mid;
   logic [KW-1:0]      kl, kr;
   logic               bad_upd, bad_qry;

   rsput_ram #(.WIDTH(VALUE_W), .DEPTH(LEAF_DEPTH)) u_leaf_ram (
      .clock (clock),
      .we    (leaf_we),
      .waddr (leaf_waddr),
      .wdata (leaf_wdata),
      .raddr (leaf_raddr),
      .rdata (leaf_rdata)
   );

   rsput_ram #(.WIDTH(VALUE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (node_waddr),
      .wdata (node_wdata),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   always_comb begin
      mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
      kl      = (k_ff << 1) + KW'(1);
      kr      = (k_ff << 1) + KW'(2);
      bad_upd = 32'(item.index) >= 32'(n_eff);
      bad_qry = bad_upd || (32'(item.range_end) >= 32'(n_eff))
                || (item.index > item.range_end);

      state_in      = state_ff;
      qa_in         = qa_ff;
      qb_in         = qb_ff;
      val_in        = val_ff;
      delta_in      = delta_ff;
      k_in          = k_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      sk_in         = sk_ff;
      slo_in        = slo_ff;
      shi_in        = shi_ff;
      clr_in        = clr_ff;
      pend_in       = 1'b0;
      acc_in        = pend_ff ? acc_ff + node_rdata : acc_ff;
      res_sum_in    = res_sum_ff;
      res_status_in = res_status_ff;

      leaf_we    = 1'b0;
      leaf_waddr = qa_ff;
      leaf_wdata = val_ff;
      leaf_raddr = PW'(item.index);
      node_we    = 1'b0;
      node_waddr = k_ff;
      node_wdata = node_rdata + delta_ff;
      node_raddr = k_ff;

      case (state_ff)
         S_CLEAR: begin
            leaf_we    = 1'b1;
            leaf_waddr = clr_ff[PW-1:0];
            leaf_wdata = '0;
            node_we    = 1'b1;
            node_waddr = clr_ff;
            node_wdata = '0;
            clr_in     = clr_ff + KW'(1);
            if (clr_ff == KW'(NODE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               qa_in         = PW'(item.index);
               qb_in         = PW'(item.range_end);
               val_in        = item.value;
               k_in          = '0;
               lo_in         = '0;
               hi_in         = PW'(n_eff - NW'(1));
               acc_in        = '0;
               res_sum_in    = '0;
               res_status_in = ST_OK;
               if (item.action == ACT_UPDATE) begin
                  if (bad_upd) begin
                     res_status_in = ST_BAD;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_LEAF;
                  end
               end else begin
                  if (bad_qry) begin
                     res_status_in = ST_BAD;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_QDESC;
                  end
               end
            end
         end
         S_LEAF: begin
            delta_in   = val_ff - leaf_rdata;
            leaf_we    = 1'b1;
            node_raddr = '0;
            state_in   = S_UWALK;
         end
         S_UWALK: begin
            node_we = 1'b1;
            if (lo_ff == hi_ff) begin
               state_in = S_DONE;
            end else if (qa_ff <= mid) begin
               k_in       = kl;
               hi_in      = mid;
               node_raddr = kl;
            end else begin
               k_in       = kr;
               lo_in      = mid + PW'(1);
               node_raddr = kr;
            end
         end
         S_QDESC: begin
            if (qa_ff <= lo_ff && qb_ff >= hi_ff) begin
               node_raddr = k_ff;
               pend_in    = 1'b1;
               state_in   = S_QDRAIN;
            end else if (qb_ff <= mid) begin
               k_in  = kl;
               hi_in = mid;
            end else if (qa_ff > mid) begin
               k_in  = kr;
               lo_in = mid + PW'(1);
            end else begin
               sk_in    = kr;
               slo_in   = mid + PW'(1);
               shi_in   = hi_ff;
               k_in     = kl;
               hi_in    = mid;
               state_in = S_QLEFT;
            end
         end
         S_QLEFT: begin
            if (qa_ff <= lo_ff) begin
               node_raddr = k_ff;
               pend_in    = 1'b1;
               k_in       = sk_ff;
               lo_in      = slo_ff;
               hi_in      = shi_ff;
               state_in   = S_QRIGHT;
            end else if (qa_ff <= mid) begin
               node_raddr = kr;
               pend_in    = 1'b1;
               k_in       = kl;
               hi_in      = mid;
            end else begin
               k_in  = kr;
               lo_in = mid + PW'(1);
            end
         end
         S_QRIGHT: begin
            if (qb_ff >= hi_ff) begin
               node_raddr = k_ff;
               pend_in    = 1'b1;
               state_in   = S_QDRAIN;
            end else if (qb_ff > mid) begin
               node_raddr = kl;
               pend_in    = 1'b1;
               k_in       = kr;
               lo_in      = mid + PW'(1);
            end else begin
               k_in  = kl;
               hi_in = mid;
            end
         end
         S_QDRAIN: begin
            res_sum_in    = acc_in;
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pend_ff  <= 1'b0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         clr_ff   <= clr_in;
      end
      qa_ff         <= qa_in;
      qb_ff         <= qb_in;
      val_ff        <= val_in;
      delta_ff      <= delta_in;
      acc_ff        <= acc_in;
      k_ff          <= k_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      sk_ff         <= sk_in;
      slo_ff        <= slo_in;
      shi_ff        <= shi_in;
      res_sum_ff    <= res_sum_in;
      res_status_ff <= res_status_in;
   end

   assign stat.idle     = (state_ff == S_IDLE);
   assign stat.done     = (state_ff == S_DONE);
   assign result.sum    = res_sum_ff;
   assign result.status = res_status_ff;

endmodule
